// ===== design/csd_pkg.sv =====
// ----------------------------------------------------------------------------
// csd_pkg
// Shared types, register indexes and codes for the clutch shift direction
// detector.
// ----------------------------------------------------------------------------
package csd_pkg;

  localparam int HISTORY_DEPTH    = 64;
  localparam int TICK_PERIOD_MS   = 50;
  localparam int SHIFT_TIMEOUT_MS = 2000;

  // Configuration register indexes
  localparam logic [2:0] REG_SWITCH_ASSIGN = 3'd0;
  localparam logic [2:0] REG_SECOND_SWITCH = 3'd1;
  localparam logic [2:0] REG_THROTTLE_PCT  = 3'd2;
  localparam logic [2:0] REG_UP_DELAY      = 3'd3;
  localparam logic [2:0] REG_LOOKBACK      = 3'd4;
  localparam logic [2:0] REG_DETECT_MODE   = 3'd5;
  localparam logic [2:0] REG_UP_RATE       = 3'd6;
  localparam logic [2:0] REG_DOWN_RATE     = 3'd7;

  // Switch assignment codes
  localparam logic [1:0] SW_NONE = 2'd0;
  localparam logic [1:0] SW_UP   = 2'd1;
  localparam logic [1:0] SW_DOWN = 2'd2;

  // Detect modes
  localparam logic [1:0] MODE_THROTTLE   = 2'd0;
  localparam logic [1:0] MODE_RPM_RATE   = 2'd1;
  localparam logic [1:0] MODE_SPEED_RATE = 2'd2;
  localparam logic [1:0] MODE_ALWAYS     = 2'd3;

  localparam logic [9:0] LOOKBACK_MIN     = 10'd100;
  localparam logic [9:0] LOOKBACK_DEFAULT = 10'd300;
  localparam logic [9:0] LOOKBACK_MAX     = 10'd1000;

  // ms per second, rates compare as delta*1000 against min*lookback
  localparam int RATE_SCALE = 1000;

  typedef struct packed {
    logic [9:0]  thr;
    logic [14:0] rpm;
    logic [11:0] spd;
  } sample_t;

  typedef struct packed {
    logic [31:0] now_ms;
    logic [9:0]  thr;
    logic [11:0] spd;      // already zero when speed is not valid
    logic        spd_ok;
    logic        clutch_up;
    logic        clutch_down;
    logic        flat;
  } item_t;

  typedef struct packed {
    logic [3:0]  switch_assign;
    logic        second_wired;
    logic [6:0]  thr_pct;
    logic [15:0] up_delay_ms;
    logic [1:0]  mode;
    logic [25:0] up_prod;   // upshift_rate_min * lookback
    logic [25:0] dn_prod;   // downshift_rate_min * lookback
  } cfg_t;

endpackage

// ===== design/csd_ring.sv =====
// ----------------------------------------------------------------------------
// csd_ring
// Sample history memory with head/fill tracking and two registered lookups.
// ----------------------------------------------------------------------------
module csd_ring
  import csd_pkg::*;
#(
  parameter int Depth = HISTORY_DEPTH,
  localparam int IdxW = $clog2(Depth),
  localparam int CntW = $clog2(Depth + 1)
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            wr_en_i,
  input  sample_t         sample_i,
  input  logic [IdxW-1:0] steps1_i,
  input  logic [IdxW-1:0] steps2_i,
  output sample_t         rd1_o,
  output sample_t         rd2_o,
  output logic            fwd_o,
  output logic            same_o
);

  sample_t         mem_q [Depth];
  sample_t         rd1_q, rd2_q;
  logic            fwd_q, same_q;
  logic [IdxW-1:0] head_q, head_d;
  logic [CntW-1:0] count_q, count_d;
  logic [IdxW-1:0] lim, eff1, eff2, addr1, addr2;

  // steps are limited to samples already written (count after this write - 1)
  assign lim  = (count_q == CntW'(Depth)) ? IdxW'(Depth - 1) : count_q[IdxW-1:0];
  assign eff1 = (steps1_i < lim) ? steps1_i : lim;
  assign eff2 = (steps2_i < lim) ? steps2_i : lim;

  // head - steps modulo Depth; head is the slot being written now
  assign addr1 = (head_q >= eff1) ? head_q - eff1 : head_q + IdxW'(Depth) - eff1;
  assign addr2 = (head_q >= eff2) ? head_q - eff2 : head_q + IdxW'(Depth) - eff2;

  assign head_d  = (head_q == IdxW'(Depth - 1)) ? '0 : head_q + IdxW'(1);
  assign count_d = (count_q == CntW'(Depth)) ? count_q : count_q + CntW'(1);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      head_q  <= '0;
      count_q <= '0;
    end else if (wr_en_i) begin
      head_q  <= head_d;
      count_q <= count_d;
    end
  end

  // read-during-write returns old data; the empty-ring case is forwarded
  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem_q[head_q] <= sample_i;
      rd1_q         <= mem_q[addr1];
      rd2_q         <= mem_q[addr2];
      fwd_q         <= (count_q == '0);
      same_q        <= (eff1 == eff2);
    end
  end

  assign rd1_o  = rd1_q;
  assign rd2_o  = rd2_q;
  assign fwd_o  = fwd_q;
  assign same_o = same_q;

endmodule

// ===== design/csd_confirm.sv =====
// ----------------------------------------------------------------------------
// csd_confirm
// Direction confirmation from history: throttle, rpm rate or speed rate.
// ----------------------------------------------------------------------------
module csd_confirm
  import csd_pkg::*;
(
  input  logic    clk_i,
  input  logic    en_i,
  input  cfg_t    cfg_i,
  input  item_t   item_i,
  input  sample_t rd1_i,
  input  sample_t rd2_i,
  input  logic    fwd_i,
  input  logic    same_i,
  output logic    ok_up_o,
  output logic    ok_dn_o,
  output logic    on_now_o
);

  logic [10:0]        thr_lim;
  logic [9:0]         thr_past;
  logic [11:0]        spd_past;
  logic               on_past, on_now;
  logic signed [16:0] delta;
  logic signed [27:0] scaled, up_ref, dn_ref;
  logic               rate_up, rate_dn;
  logic               ok_up, ok_dn;
  logic               ok_up_q, ok_dn_q, on_now_q;

  assign thr_lim  = 11'(cfg_i.thr_pct) * 11'd10;
  assign thr_past = fwd_i ? item_i.thr : rd1_i.thr;
  assign spd_past = fwd_i ? item_i.spd : rd1_i.spd;
  assign on_past  = {1'b0, thr_past} >= thr_lim;
  assign on_now   = {1'b0, item_i.thr} >= thr_lim;

  always_comb begin
    if (cfg_i.mode == MODE_RPM_RATE) begin
      delta = $signed({2'b0, rd1_i.rpm}) - $signed({2'b0, rd2_i.rpm});
    end else begin
      delta = $signed({5'b0, item_i.spd}) - $signed({5'b0, spd_past});
    end
  end

  assign scaled  = 28'(delta) * $signed(28'(RATE_SCALE));
  assign up_ref  = $signed({2'b0, cfg_i.up_prod});
  assign dn_ref  = $signed({2'b0, cfg_i.dn_prod});
  assign rate_up = scaled > up_ref;
  assign rate_dn = scaled < -dn_ref;

  always_comb begin
    case (cfg_i.mode)
      MODE_THROTTLE: begin
        ok_up = on_past;
        ok_dn = !on_past;
      end
      MODE_RPM_RATE: begin
        ok_up = same_i || rate_up;
        ok_dn = same_i || rate_dn;
      end
      MODE_SPEED_RATE: begin
        // no speed sensor: fall back to throttle
        ok_up = item_i.spd_ok ? rate_up : on_past;
        ok_dn = item_i.spd_ok ? rate_dn : !on_past;
      end
      default: begin
        ok_up = 1'b1;
        ok_dn = 1'b1;
      end
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      ok_up_q  <= ok_up;
      ok_dn_q  <= ok_dn;
      on_now_q <= on_now;
    end
  end

  assign ok_up_o  = ok_up_q;
  assign ok_dn_o  = ok_dn_q;
  assign on_now_o = on_now_q;

endmodule

// ===== design/csd_window.sv =====
// ----------------------------------------------------------------------------
// csd_window
// Shift window state: clutch edges, open/close, delay and the result flags.
// ----------------------------------------------------------------------------
module csd_window
  import csd_pkg::*;
#(
  parameter int ShiftTimeoutMs = SHIFT_TIMEOUT_MS
) (
  input  logic  clk_i,
  input  logic  rst_ni,
  input  logic  en_i,
  input  cfg_t  cfg_i,
  input  item_t item_i,
  input  logic  on_now_i,
  input  logic  ok_up_i,
  input  logic  ok_dn_i,
  output logic  upshifting_o,
  output logic  downshifting_o,
  output logic  window_open_o
);

  localparam logic [31:0] Timeout = 32'(ShiftTimeoutMs);

  logic        prev_up_q, prev_up_d, prev_dn_q, prev_dn_d;
  logic        win_q, win_d, dir_q, dir_d, up_q, up_d, dn_q, dn_d;
  logic [31:0] start_q, start_d, eval_q, eval_d;

  logic [1:0]  up_sw, dn_sw, dir_sw_open, dir_sw;
  logic        up_fell, up_rose, dn_fell, dn_rose, up_wired, dn_wired;
  logic        open, dir_open, own_close, early_close, timed_out, ok;
  logic [31:0] elapsed;

  assign up_sw = cfg_i.switch_assign[1:0];
  assign dn_sw = cfg_i.switch_assign[3:2];

  assign up_fell = !item_i.clutch_up && prev_up_q;
  assign up_rose = item_i.clutch_up && !prev_up_q;
  assign dn_fell = !item_i.clutch_down && prev_dn_q;
  assign dn_rose = item_i.clutch_down && !prev_dn_q;

  assign up_wired = (up_sw == SW_UP) || (dn_sw == SW_UP) || cfg_i.second_wired;
  assign dn_wired = (up_sw == SW_DOWN) || (dn_sw == SW_DOWN) || cfg_i.second_wired;
  assign open     = !win_q && ((up_wired && up_fell) || (dn_wired && dn_rose));

  always_comb begin
    if (up_sw != SW_NONE && dn_sw != SW_NONE) begin
      if (up_sw == dn_sw) begin
        // one switch for both directions: throttle decides
        dir_open = on_now_i;
      end else if (up_sw == SW_UP) begin
        dir_open = up_fell;
      end else if (up_sw == SW_DOWN) begin
        dir_open = dn_rose;
      end else begin
        dir_open = 1'b0;
      end
    end else begin
      dir_open = (up_sw != SW_NONE);
    end
  end

  assign dir_sw_open = dir_open ? up_sw : dn_sw;

  always_comb begin
    prev_up_d = prev_up_q;
    prev_dn_d = prev_dn_q;
    win_d     = win_q;
    dir_d     = dir_q;
    start_d   = start_q;
    eval_d    = eval_q;
    up_d      = up_q;
    dn_d      = dn_q;
    if (open) begin
      win_d   = 1'b1;
      dir_d   = dir_open;
      start_d = item_i.now_ms;
      eval_d  = item_i.now_ms + ((dir_sw_open == SW_UP) ? 32'(cfg_i.up_delay_ms) : 32'd0);
    end
    dir_sw      = dir_d ? up_sw : dn_sw;
    own_close   = (dir_sw == SW_UP) ? up_rose : ((dir_sw == SW_DOWN) ? dn_fell : 1'b0);
    early_close = cfg_i.second_wired && (dir_sw == SW_UP) && dn_fell;
    elapsed     = item_i.now_ms - start_d;
    timed_out   = elapsed > Timeout;
    ok          = dir_d ? ok_up_i : ok_dn_i;

    if (item_i.flat) begin
      // flat shift: forced upshift, switch history untouched
      win_d   = 1'b0;
      dir_d   = dir_q;
      start_d = start_q;
      eval_d  = eval_q;
      up_d    = 1'b1;
      dn_d    = 1'b0;
    end else if (up_sw == SW_NONE && dn_sw == SW_NONE) begin
      win_d   = win_q;
      dir_d   = dir_q;
      start_d = start_q;
      eval_d  = eval_q;
      up_d    = 1'b0;
      dn_d    = 1'b0;
    end else begin
      prev_up_d = item_i.clutch_up;
      prev_dn_d = item_i.clutch_down;
      if (!win_d) begin
        up_d = 1'b0;
        dn_d = 1'b0;
      end else if (own_close || early_close || timed_out) begin
        win_d = 1'b0;
        up_d  = 1'b0;
        dn_d  = 1'b0;
      end else if (item_i.now_ms >= eval_d) begin
        up_d = dir_d && ok;
        dn_d = !dir_d && ok;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      prev_up_q <= 1'b0;
      prev_dn_q <= 1'b0;
      win_q     <= 1'b0;
      dir_q     <= 1'b0;
      start_q   <= '0;
      eval_q    <= '0;
      up_q      <= 1'b0;
      dn_q      <= 1'b0;
    end else if (en_i) begin
      prev_up_q <= prev_up_d;
      prev_dn_q <= prev_dn_d;
      win_q     <= win_d;
      dir_q     <= dir_d;
      start_q   <= start_d;
      eval_q    <= eval_d;
      up_q      <= up_d;
      dn_q      <= dn_d;
    end
  end

  assign upshifting_o   = up_q;
  assign downshifting_o = dn_q;
  assign window_open_o  = win_q;

endmodule

// ===== design/clutch_shift_direction_detector.sv =====
// ----------------------------------------------------------------------------
// clutch_shift_direction_detector
// Detects clutch shifts, opens a shift window and confirms its direction from
// a history of throttle, rpm and speed samples.
// ----------------------------------------------------------------------------
//
//  channel | direction | handshake               | carries
//  --------+-----------+-------------------------+-------------------------------
//  in      | input     | in_valid_i / in_ready_o | one tick: time, throttle, rpm,
//          |           |                         | speed, clutch switches, flat
//  out     | output    | out_valid_o/out_ready_i | upshifting, downshifting,
//          |           |                         | window_open
//  cfg     | input     | cfg_valid_i/cfg_ready_o | register index + data (16 bits)
//
// Pipeline: three stages, one item per cycle sustained while results are taken;
//   each item is registered by stages 1, 2 and 3 in turn. Stage 1 writes the
//   tick into the sample memory and does both history lookups (two read ports,
//   registered data); stage 2 does the rate/throttle compares; stage 3 updates
//   the window state and holds it as the result.
// Reset: control state clears at once; the sample memory needs no clearing
//   since lookups only reach samples already written (fill count).
// Stalls: a held result stalls stage 3 only; upstream stages keep filling, so
//   in_ready_o drops only once all three stages are full. cfg is always ready.
// ----------------------------------------------------------------------------
module clutch_shift_direction_detector
  import csd_pkg::*;
#(
  parameter int HistoryDepth   = HISTORY_DEPTH,
  parameter int TickPeriodMs   = TICK_PERIOD_MS,
  parameter int ShiftTimeoutMs = SHIFT_TIMEOUT_MS
) (
  input  logic        clk_i,
  input  logic        rst_ni,

  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic [31:0] now_ms_i,
  input  logic [9:0]  throttle_tenths_i,
  input  logic [14:0] engine_rpm_i,
  input  logic [11:0] speed_tenths_i,
  input  logic        speed_valid_i,
  input  logic        clutch_up_sw_i,
  input  logic        clutch_down_sw_i,
  input  logic        flat_shift_i,

  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic        upshifting_o,
  output logic        downshifting_o,
  output logic        window_open_o,

  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [2:0]  cfg_index_i,
  input  logic [15:0] cfg_data_i
);

  localparam int IdxW = $clog2(HistoryDepth);

  // lookback / tick period by reciprocal: exact floor for dividends < 2^11
  // as long as dividend * period < 2^RecipShift
  localparam int          RecipShift = 22;
  localparam int          MulW       = RecipShift + 1;
  localparam int          ProdW      = MulW + 11;
  localparam longint      RecipMul   =
    ((longint'(1) << RecipShift) + longint'(TickPeriodMs) - 1) / TickPeriodMs;
  localparam logic [MulW-1:0] RecipMulV = MulW'(RecipMul);

  // step counts for the reset lookback
  localparam int Q1Rst = int'(LOOKBACK_DEFAULT) / TickPeriodMs;
  localparam int Q2Rst = (2 * int'(LOOKBACK_DEFAULT)) / TickPeriodMs;
  localparam int S1Rst = (Q1Rst < 1) ? 1 : ((Q1Rst > HistoryDepth - 1) ? HistoryDepth - 1 : Q1Rst);
  localparam int S2Rst = (Q2Rst < 1) ? 1 : ((Q2Rst > HistoryDepth - 1) ? HistoryDepth - 1 : Q2Rst);

  localparam logic [10:0]     MaxStepsW = 11'(HistoryDepth - 1);
  localparam logic [IdxW-1:0] MaxSteps  = IdxW'(HistoryDepth - 1);

  // --------------------------------------------------------------------------
  // Configuration registers
  // --------------------------------------------------------------------------
  logic        cfg_we;
  logic [3:0]  sa_q, sa_d;
  logic        second_q, second_d;
  logic [6:0]  pct_q, pct_d;
  logic [15:0] delay_q, delay_d;
  logic [9:0]  lb_q, lb_d, lb_wr;
  logic [1:0]  mode_q, mode_d;
  logic [15:0] up_min_q, up_min_d, dn_min_q, dn_min_d;
  logic [25:0] up_prod_q, dn_prod_q;
  logic [IdxW-1:0] steps1_q, steps1_d, steps2_q, steps2_d;
  logic [ProdW-1:0] q1_prod, q2_prod;
  logic [10:0]     q1, q2;
  cfg_t            cfg;

  assign cfg_ready_o = 1'b1;
  assign cfg_we      = cfg_valid_i && cfg_ready_o;

  // lookback below the minimum falls back to the default, above max clamps
  assign lb_wr = (cfg_data_i < 16'(LOOKBACK_MIN)) ? LOOKBACK_DEFAULT :
                 (cfg_data_i > 16'(LOOKBACK_MAX)) ? LOOKBACK_MAX : cfg_data_i[9:0];

  always_comb begin
    sa_d     = sa_q;
    second_d = second_q;
    pct_d    = pct_q;
    delay_d  = delay_q;
    lb_d     = lb_q;
    mode_d   = mode_q;
    up_min_d = up_min_q;
    dn_min_d = dn_min_q;
    if (cfg_we) begin
      case (cfg_index_i)
        REG_SWITCH_ASSIGN: sa_d     = cfg_data_i[3:0];
        REG_SECOND_SWITCH: second_d = cfg_data_i[0];
        REG_THROTTLE_PCT:  pct_d    = cfg_data_i[6:0];
        REG_UP_DELAY:      delay_d  = cfg_data_i;
        REG_LOOKBACK:      lb_d     = lb_wr;
        REG_DETECT_MODE:   mode_d   = cfg_data_i[1:0];
        REG_UP_RATE:       up_min_d = cfg_data_i;
        REG_DOWN_RATE:     dn_min_d = cfg_data_i;
        default: ;
      endcase
    end
  end

  // lookback and twice lookback in ticks, clamped to [1, depth-1]
  assign q1_prod = ProdW'(lb_d) * ProdW'(RecipMulV);
  assign q2_prod = ProdW'({lb_d, 1'b0}) * ProdW'(RecipMulV);
  assign q1      = q1_prod[RecipShift +: 11];
  assign q2      = q2_prod[RecipShift +: 11];

  assign steps1_d = (q1 == '0) ? IdxW'(1) : ((q1 > MaxStepsW) ? MaxSteps : q1[IdxW-1:0]);
  assign steps2_d = (q2 == '0) ? IdxW'(1) : ((q2 > MaxStepsW) ? MaxSteps : q2[IdxW-1:0]);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sa_q      <= '0;
      second_q  <= 1'b0;
      pct_q     <= '0;
      delay_q   <= '0;
      lb_q      <= LOOKBACK_DEFAULT;
      mode_q    <= MODE_THROTTLE;
      up_min_q  <= '0;
      dn_min_q  <= '0;
      up_prod_q <= '0;
      dn_prod_q <= '0;
      steps1_q  <= IdxW'(S1Rst);
      steps2_q  <= IdxW'(S2Rst);
    end else begin
      sa_q      <= sa_d;
      second_q  <= second_d;
      pct_q     <= pct_d;
      delay_q   <= delay_d;
      lb_q      <= lb_d;
      mode_q    <= mode_d;
      up_min_q  <= up_min_d;
      dn_min_q  <= dn_min_d;
      // rate thresholds pre-scaled by lookback so no divide is needed
      up_prod_q <= 26'(up_min_d) * 26'(lb_d);
      dn_prod_q <= 26'(dn_min_d) * 26'(lb_d);
      steps1_q  <= steps1_d;
      steps2_q  <= steps2_d;
    end
  end

  assign cfg.switch_assign = sa_q;
  assign cfg.second_wired  = second_q;
  assign cfg.thr_pct       = pct_q;
  assign cfg.up_delay_ms   = delay_q;
  assign cfg.mode          = mode_q;
  assign cfg.up_prod       = up_prod_q;
  assign cfg.dn_prod       = dn_prod_q;

  // --------------------------------------------------------------------------
  // Pipeline control
  // --------------------------------------------------------------------------
  logic  in_acc, out_free, s1_go, s1_free, s2_go, s2_free;
  logic  s1_valid_q, s2_valid_q, out_valid_q;
  item_t item_in, s1_item_q, s2_item_q;
  sample_t sample_in, rd1, rd2;
  logic  fwd, same;
  logic  ok_up, ok_dn, on_now;

  assign out_free = !out_valid_q || out_ready_i;
  assign s2_go    = s2_valid_q && out_free;
  assign s2_free  = !s2_valid_q || out_free;
  assign s1_go    = s1_valid_q && s2_free;
  assign s1_free  = !s1_valid_q || s2_free;

  assign in_ready_o = s1_free;
  assign in_acc     = in_valid_i && in_ready_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q  <= 1'b0;
      s2_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      s1_valid_q  <= in_acc || (s1_valid_q && !s2_free);
      s2_valid_q  <= s1_go || (s2_valid_q && !out_free);
      out_valid_q <= s2_go || (out_valid_q && !out_ready_i);
    end
  end

  // speed is recorded as zero when the sensor reports it invalid
  assign item_in.now_ms      = now_ms_i;
  assign item_in.thr         = throttle_tenths_i;
  assign item_in.spd         = speed_valid_i ? speed_tenths_i : 12'd0;
  assign item_in.spd_ok      = speed_valid_i;
  assign item_in.clutch_up   = clutch_up_sw_i;
  assign item_in.clutch_down = clutch_down_sw_i;
  assign item_in.flat        = flat_shift_i;

  assign sample_in.thr = item_in.thr;
  assign sample_in.rpm = engine_rpm_i;
  assign sample_in.spd = item_in.spd;

  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      s1_item_q <= item_in;
    end
    if (s1_go) begin
      s2_item_q <= s1_item_q;
    end
  end

  // --------------------------------------------------------------------------
  // Stage 1: sample memory write and history lookups
  // --------------------------------------------------------------------------
  csd_ring #(
    .Depth (HistoryDepth)
  ) u_ring (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .wr_en_i  (in_acc),
    .sample_i (sample_in),
    .steps1_i (steps1_q),
    .steps2_i (steps2_q),
    .rd1_o    (rd1),
    .rd2_o    (rd2),
    .fwd_o    (fwd),
    .same_o   (same)
  );

  // --------------------------------------------------------------------------
  // Stage 2: confirm compares, evaluated for both directions
  // --------------------------------------------------------------------------
  csd_confirm u_confirm (
    .clk_i    (clk_i),
    .en_i     (s1_go),
    .cfg_i    (cfg),
    .item_i   (s1_item_q),
    .rd1_i    (rd1),
    .rd2_i    (rd2),
    .fwd_i    (fwd),
    .same_i   (same),
    .ok_up_o  (ok_up),
    .ok_dn_o  (ok_dn),
    .on_now_o (on_now)
  );

  // --------------------------------------------------------------------------
  // Stage 3: window state; its flags are the result
  // --------------------------------------------------------------------------
  csd_window #(
    .ShiftTimeoutMs (ShiftTimeoutMs)
  ) u_window (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .en_i           (s2_go),
    .cfg_i          (cfg),
    .item_i         (s2_item_q),
    .on_now_i       (on_now),
    .ok_up_i        (ok_up),
    .ok_dn_i        (ok_dn),
    .upshifting_o   (upshifting_o),
    .downshifting_o (downshifting_o),
    .window_open_o  (window_open_o)
  );

  assign out_valid_o = out_valid_q;

endmodule

// ===== design/csd_checker.sv =====
// ----------------------------------------------------------------------------
// csd_checker
// Port-level checks for the clutch shift direction detector.
// ----------------------------------------------------------------------------
module csd_checker (
  input logic clk_i,
  input logic rst_ni,
  input logic in_valid_i,
  input logic in_ready_o,
  input logic out_valid_o,
  input logic out_ready_i,
  input logic upshifting_o,
  input logic downshifting_o,
  input logic window_open_o
);

  // never both directions at once
  a_one_direction: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> !(upshifting_o && downshifting_o))
    else $error("upshift and downshift both set");

  // a confirmed downshift only exists inside an open window
  a_down_in_window: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && downshifting_o) |-> window_open_o)
    else $error("downshift reported with window closed");

  // input back-pressure only comes from a stalled result with a full pipe
  a_ready_only_on_stall: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !in_ready_o |-> (out_valid_o && !out_ready_i))
    else $error("input stalled without output back-pressure");

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && !out_ready_i) |=>
      (out_valid_o && $stable({upshifting_o, downshifting_o, window_open_o})))
    else $error("result changed while stalled");

endmodule

bind clutch_shift_direction_detector csd_checker u_csd_checker (.*);
